FILE: rtl/least_squares_line_fit_unit_assert.svh
// Assertion macros shared by the least-squares line fit unit.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef LEAST_SQUARES_LINE_FIT_UNIT_ASSERT_SVH
`define LEAST_SQUARES_LINE_FIT_UNIT_ASSERT_SVH

// Same-cycle implication.
`define LSLF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LSLF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lslf_pkg.sv
package lslf_pkg;

  localparam int MAX_POINTS  = 1024;
  localparam int CNT_W       = 11;
  localparam int SUM_W       = 34;
  localparam int ACC_W       = 57;
  localparam int ACC_ENTRIES = 5;
  localparam int AADDR_W     = 3;

  // Width of the magnitudes handled by the shared multiply/divide unit.
  localparam int MAG_W    = 160;
  localparam int SGN_W    = MAG_W + 1;
  localparam int MUL_BITS = 72;
  localparam int ITER_W   = 8;

  // Accumulator memory map.
  localparam logic [AADDR_W-1:0] ADDR_SX  = 3'd0;
  localparam logic [AADDR_W-1:0] ADDR_SY  = 3'd1;
  localparam logic [AADDR_W-1:0] ADDR_SXX = 3'd2;
  localparam logic [AADDR_W-1:0] ADDR_SYY = 3'd3;
  localparam logic [AADDR_W-1:0] ADDR_SXY = 3'd4;

  // Fit status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_X_FLAT = 2'd1;
  localparam logic [1:0] ST_Y_FLAT = 2'd2;
  localparam logic [1:0] ST_SAT    = 2'd3;

  typedef struct packed {
    logic signed [23:0] x_value;
    logic signed [23:0] y_value;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic [16:0]        r_squared;
    logic [1:0]         fit_status;
    logic [10:0]        points_used;
  } fit_result_t;

  typedef struct packed {
    logic [CNT_W-1:0]        n;
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [ACC_W-1:0] sxx;
    logic signed [ACC_W-1:0] syy;
    logic signed [ACC_W-1:0] sxy;
  } sums_t;

  typedef struct packed {
    logic start;
    logic op_div;
  } mdu_req_t;

endpackage

FILE: rtl/lslf_acc.sv
module lslf_acc (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  lslf_pkg::point_t point_i,
  output logic             busy_o,
  output logic             sums_valid_o,
  output lslf_pkg::sums_t  sums_o
);

  logic                                  active_q;
  logic [lslf_pkg::AADDR_W-1:0]          step_q;
  logic                                  last_q;
  logic                                  full_q;
  logic                                  fresh_q;
  logic [lslf_pkg::CNT_W-1:0]            count_q;
  logic                                  sums_valid_q;
  logic signed [23:0]                    x_q;
  logic signed [23:0]                    y_q;
  logic signed [47:0]                    xx_q;
  logic signed [47:0]                    yy_q;
  logic signed [47:0]                    xy_q;
  logic signed [lslf_pkg::ACC_W-1:0]     rdata_q;
  logic signed [lslf_pkg::ACC_W-1:0]     mem [lslf_pkg::ACC_ENTRIES];
  lslf_pkg::sums_t                       sums_q;
  logic [lslf_pkg::AADDR_W-1:0]          wr_addr;
  logic signed [lslf_pkg::ACC_W-1:0]     term;
  logic signed [lslf_pkg::ACC_W-1:0]     base;
  logic signed [lslf_pkg::ACC_W-1:0]     wsum;
  logic                                  last_step;

  assign wr_addr   = step_q - 3'd1;
  assign last_step = (step_q == lslf_pkg::AADDR_W'(lslf_pkg::ACC_ENTRIES));

  always_comb begin
    case (wr_addr)
      lslf_pkg::ADDR_SX:  term = lslf_pkg::ACC_W'(x_q);
      lslf_pkg::ADDR_SY:  term = lslf_pkg::ACC_W'(y_q);
      lslf_pkg::ADDR_SXX: term = lslf_pkg::ACC_W'(xx_q);
      lslf_pkg::ADDR_SYY: term = lslf_pkg::ACC_W'(yy_q);
      default:            term = lslf_pkg::ACC_W'(xy_q);
    endcase
    if (full_q) begin
      term = '0;
    end
    // The first point of a data set sees the old totals as zero.
    base = fresh_q ? '0 : rdata_q;
    wsum = base + term;
  end

  // Accumulator memory: one read and one write per cycle, distinct entries.
  always_ff @(posedge clk_i) begin
    if (active_q && (step_q < lslf_pkg::AADDR_W'(lslf_pkg::ACC_ENTRIES))) begin
      rdata_q <= mem[step_q];
    end
    if (active_q && (step_q != '0) && !full_q) begin
      mem[wr_addr] <= wsum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      x_q <= point_i.x_value;
      y_q <= point_i.y_value;
    end
    if (active_q && (step_q == '0)) begin
      xx_q <= x_q * x_q;
      yy_q <= y_q * y_q;
      xy_q <= x_q * y_q;
    end
    if (active_q && (step_q != '0)) begin
      case (wr_addr)
        lslf_pkg::ADDR_SX:  sums_q.sx  <= wsum[lslf_pkg::SUM_W-1:0];
        lslf_pkg::ADDR_SY:  sums_q.sy  <= wsum[lslf_pkg::SUM_W-1:0];
        lslf_pkg::ADDR_SXX: sums_q.sxx <= wsum;
        lslf_pkg::ADDR_SYY: sums_q.syy <= wsum;
        default:            sums_q.sxy <= wsum;
      endcase
    end
    if (active_q && last_step) begin
      sums_q.n <= full_q ? count_q : count_q + 11'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      step_q       <= '0;
      last_q       <= 1'b0;
      full_q       <= 1'b0;
      fresh_q      <= 1'b0;
      count_q      <= '0;
      sums_valid_q <= 1'b0;
    end else begin
      sums_valid_q <= active_q && !accept_i && last_step && last_q;
      if (accept_i) begin
        active_q <= 1'b1;
        step_q   <= '0;
        last_q   <= point_i.last_point;
        full_q   <= (count_q == lslf_pkg::CNT_W'(lslf_pkg::MAX_POINTS));
        fresh_q  <= (count_q == '0);
      end else if (active_q) begin
        step_q <= step_q + 3'd1;
        if (last_step) begin
          active_q <= 1'b0;
          if (last_q) begin
            count_q <= '0;
          end else if (!full_q) begin
            count_q <= count_q + 11'd1;
          end
        end
      end
    end
  end

  assign busy_o       = active_q;
  assign sums_valid_o = sums_valid_q;
  assign sums_o       = sums_q;

endmodule

FILE: rtl/lslf_mdu.sv
module lslf_mdu (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lslf_pkg::mdu_req_t         req_i,
  input  logic [lslf_pkg::MAG_W-1:0] a_i,
  input  logic [lslf_pkg::MAG_W-1:0] b_i,
  output logic                       done_o,
  output logic [lslf_pkg::MAG_W-1:0] res_o
);

  logic                        busy_q;
  logic                        div_q;
  logic                        done_q;
  logic [lslf_pkg::ITER_W-1:0] cnt_q;
  logic [lslf_pkg::MAG_W-1:0]  acc_q;
  logic [lslf_pkg::MAG_W-1:0]  opa_q;
  logic [lslf_pkg::MAG_W-1:0]  opb_q;
  logic [lslf_pkg::MAG_W:0]    den_q;
  logic [lslf_pkg::MAG_W:0]    rem_q;
  logic [lslf_pkg::MAG_W:0]    num_ext;
  logic [lslf_pkg::MAG_W+1:0]  rem_sh;
  logic [lslf_pkg::MAG_W+1:0]  diff;
  logic                        ge;

  // Rounded division: floor((2a + b) / 2b).
  assign num_ext = {a_i, 1'b0} + {1'b0, b_i};
  assign rem_sh  = {rem_q, opb_q[lslf_pkg::MAG_W-1]};
  assign ge      = (rem_sh >= {1'b0, den_q});
  assign diff    = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !req_i.start && busy_q && (cnt_q == 8'd1);
      if (req_i.start) begin
        busy_q <= 1'b1;
        div_q  <= req_i.op_div;
        cnt_q  <= req_i.op_div ? lslf_pkg::ITER_W'(lslf_pkg::MAG_W)
                               : lslf_pkg::ITER_W'(lslf_pkg::MUL_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 8'd1;
        if (cnt_q == 8'd1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      rem_q <= '0;
      opa_q <= a_i;
      den_q <= {b_i, 1'b0};
      opb_q <= req_i.op_div ? num_ext[lslf_pkg::MAG_W-1:0] : b_i;
    end else if (busy_q) begin
      if (div_q) begin
        rem_q <= ge ? diff[lslf_pkg::MAG_W:0] : rem_sh[lslf_pkg::MAG_W:0];
        acc_q <= {acc_q[lslf_pkg::MAG_W-2:0], ge};
        opb_q <= {opb_q[lslf_pkg::MAG_W-2:0], 1'b0};
      end else begin
        if (opb_q[0]) begin
          acc_q <= acc_q + opa_q;
        end
        opa_q <= {opa_q[lslf_pkg::MAG_W-2:0], 1'b0};
        opb_q <= {1'b0, opb_q[lslf_pkg::MAG_W-1:1]};
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

FILE: rtl/lslf_fit.sv
module lslf_fit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  sums_valid_i,
  input  lslf_pkg::sums_t       sums_i,
  output logic                  busy_o,
  output logic                  done_o,
  output lslf_pkg::fit_result_t result_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_CHKX  = 3'd3;
  localparam logic [2:0] S_CHKY  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  localparam logic [3:0] STP_NSXX  = 4'd0;
  localparam logic [3:0] STP_SXSX  = 4'd1;
  localparam logic [3:0] STP_NSYY  = 4'd2;
  localparam logic [3:0] STP_SYSY  = 4'd3;
  localparam logic [3:0] STP_NSXY  = 4'd4;
  localparam logic [3:0] STP_SXSY  = 4'd5;
  localparam logic [3:0] STP_SLOPE = 4'd6;
  localparam logic [3:0] STP_SYSXX = 4'd7;
  localparam logic [3:0] STP_SXSXY = 4'd8;
  localparam logic [3:0] STP_ICPT  = 4'd9;
  localparam logic [3:0] STP_DXYSQ = 4'd10;
  localparam logic [3:0] STP_DEN   = 4'd11;
  localparam logic [3:0] STP_R2    = 4'd12;

  localparam int SW = lslf_pkg::SGN_W;
  localparam int MW = lslf_pkg::MAG_W;

  logic [2:0]              state_q;
  logic [3:0]              step_q;
  lslf_pkg::sums_t         sums_q;
  logic signed [SW-1:0]    prod_q [13];
  logic signed [31:0]      slope_q;
  logic signed [31:0]      icpt_q;
  logic [16:0]             r2_q;
  logic [1:0]              status_q;
  logic                    sat_q;

  logic signed [SW-1:0]    n_s;
  logic signed [SW-1:0]    dxx;
  logic signed [SW-1:0]    dyy;
  logic signed [SW-1:0]    dxy;
  logic signed [SW-1:0]    bnum;
  logic signed [SW-1:0]    op_a;
  logic signed [SW-1:0]    op_b;
  logic signed [SW-1:0]    neg_a_val;
  logic signed [SW-1:0]    neg_b_val;
  logic                    op_div;
  logic                    neg_a;
  logic                    neg_b;
  logic [MW-1:0]           mag_a;
  logic [MW-1:0]           mag_b;
  logic [MW-1:0]           res;
  logic                    mdu_done;
  logic signed [SW-1:0]    res_s;
  logic [MW-1:0]           lim;
  logic                    sat_hit;
  logic [31:0]             mag32;
  logic [31:0]             q32;
  lslf_pkg::mdu_req_t      req;

  assign n_s  = SW'($signed({1'b0, sums_q.n}));
  assign dxx  = prod_q[STP_NSXX] - prod_q[STP_SXSX];
  assign dyy  = prod_q[STP_NSYY] - prod_q[STP_SYSY];
  assign dxy  = prod_q[STP_NSXY] - prod_q[STP_SXSY];
  assign bnum = prod_q[STP_SYSXX] - prod_q[STP_SXSXY];

  always_comb begin
    op_div = 1'b0;
    op_a   = '0;
    op_b   = '0;
    case (step_q)
      STP_NSXX:  begin op_a = n_s;            op_b = SW'(sums_q.sxx); end
      STP_SXSX:  begin op_a = SW'(sums_q.sx); op_b = SW'(sums_q.sx);  end
      STP_NSYY:  begin op_a = n_s;            op_b = SW'(sums_q.syy); end
      STP_SYSY:  begin op_a = SW'(sums_q.sy); op_b = SW'(sums_q.sy);  end
      STP_NSXY:  begin op_a = n_s;            op_b = SW'(sums_q.sxy); end
      STP_SXSY:  begin op_a = SW'(sums_q.sx); op_b = SW'(sums_q.sy);  end
      STP_SLOPE: begin op_div = 1'b1; op_a = dxy <<< 16; op_b = dxx; end
      STP_SYSXX: begin op_a = SW'(sums_q.sy); op_b = SW'(sums_q.sxx); end
      STP_SXSXY: begin op_a = SW'(sums_q.sx); op_b = SW'(sums_q.sxy); end
      STP_ICPT:  begin op_div = 1'b1; op_a = bnum; op_b = dxx; end
      STP_DXYSQ: begin op_a = dxy; op_b = dxy; end
      STP_DEN:   begin op_a = dxx; op_b = dyy; end
      STP_R2:    begin
        op_div = 1'b1;
        op_a   = prod_q[STP_DXYSQ] <<< 16;
        op_b   = prod_q[STP_DEN];
      end
      default:   begin op_a = '0; op_b = '0; end
    endcase
  end

  assign neg_a     = op_a[SW-1];
  assign neg_b     = op_b[SW-1];
  assign neg_a_val = -op_a;
  assign neg_b_val = -op_b;
  assign mag_a     = neg_a ? neg_a_val[MW-1:0] : op_a[MW-1:0];
  assign mag_b     = neg_b ? neg_b_val[MW-1:0] : op_b[MW-1:0];

  assign req.start  = (state_q == S_ISSUE);
  assign req.op_div = op_div;

  lslf_mdu u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (mag_a),
    .b_i    (mag_b),
    .done_o (mdu_done),
    .res_o  (res)
  );

  // Products carry the sign of both operands; quotients carry the numerator's.
  assign res_s   = (neg_a ^ neg_b) ? -$signed({1'b0, res}) : $signed({1'b0, res});
  assign lim     = neg_a ? MW'(32'h8000_0000) : MW'(32'h7FFF_FFFF);
  assign sat_hit = (res > lim);
  assign mag32   = sat_hit ? lim[31:0] : res[31:0];
  assign q32     = neg_a ? (32'd0 - mag32) : mag32;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (sums_valid_i) begin
            step_q  <= STP_NSXX;
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: state_q <= S_WAIT;
        S_WAIT: begin
          if (mdu_done) begin
            if (step_q == STP_SXSY) begin
              state_q <= S_CHKX;
            end else if (step_q == STP_ICPT) begin
              state_q <= S_CHKY;
            end else if (step_q == STP_R2) begin
              state_q <= S_FIN;
            end else begin
              step_q  <= step_q + 4'd1;
              state_q <= S_ISSUE;
            end
          end
        end
        S_CHKX: begin
          if (dxx <= 0) begin
            state_q <= S_FIN;
          end else begin
            step_q  <= STP_SLOPE;
            state_q <= S_ISSUE;
          end
        end
        S_CHKY: begin
          if (dyy <= 0) begin
            state_q <= S_FIN;
          end else begin
            step_q  <= STP_DXYSQ;
            state_q <= S_ISSUE;
          end
        end
        S_FIN:   state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && sums_valid_i) begin
      sums_q   <= sums_i;
      slope_q  <= '0;
      icpt_q   <= '0;
      r2_q     <= '0;
      status_q <= lslf_pkg::ST_OK;
      sat_q    <= 1'b0;
    end
    if ((state_q == S_WAIT) && mdu_done) begin
      case (step_q)
        STP_SLOPE: begin
          slope_q <= q32;
          sat_q   <= sat_q | sat_hit;
        end
        STP_ICPT: begin
          icpt_q <= q32;
          sat_q  <= sat_q | sat_hit;
        end
        STP_R2: begin
          r2_q     <= (res > MW'(17'd65536)) ? 17'd65536 : res[16:0];
          status_q <= sat_q ? lslf_pkg::ST_SAT : lslf_pkg::ST_OK;
        end
        default: prod_q[step_q] <= res_s;
      endcase
    end
    if ((state_q == S_CHKX) && (dxx <= 0)) begin
      status_q <= lslf_pkg::ST_X_FLAT;
    end
    if ((state_q == S_CHKY) && (dyy <= 0)) begin
      status_q <= lslf_pkg::ST_Y_FLAT;
    end
  end

  assign busy_o = (state_q != S_IDLE) || sums_valid_i;
  assign done_o = (state_q == S_FIN);

  assign result_o.slope       = slope_q;
  assign result_o.intercept   = icpt_q;
  assign result_o.r_squared   = r2_q;
  assign result_o.fit_status  = status_q;
  assign result_o.points_used = sums_q.n;

endmodule

FILE: rtl/least_squares_line_fit_unit.sv
// Channel   Ports                      Direction  Transfer
// point     start, busy, item_i        in         start high while busy low
// result    done_o, result_o           out        one-cycle strobe on done_o
//
// Each point is taken and then occupies the block while the five running totals in the
// accumulator memory are read, updated and written back one entry at a time; a point
// past the store limit leaves them unchanged. The point marked last also starts the fit:
// one shared shift-add multiplier and restoring divider runs ten multiplies and three
// divisions; six multiplies alone when x has no spread, eight and two when y has none.
// After reset the totals count as zero; no clearing pass is needed.
// The result is shown for exactly one cycle and cannot be held off by the receiver.

`include "least_squares_line_fit_unit_assert.svh"

module least_squares_line_fit_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  lslf_pkg::point_t      item_i,
  output logic                  done_o,
  output lslf_pkg::fit_result_t result_o
);

  logic            accept;
  logic            acc_busy;
  logic            fit_busy;
  logic            sums_valid;
  lslf_pkg::sums_t sums;

  // A new item is taken only when neither the totals update nor a fit is running.
  assign accept = start && !busy;
  assign busy   = acc_busy || fit_busy;

  // Running totals live in a small memory and are updated one entry per cycle.
  lslf_acc u_acc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .point_i      (item_i),
    .busy_o       (acc_busy),
    .sums_valid_o (sums_valid),
    .sums_o       (sums)
  );

  // The fit sequencer turns the final totals into slope, intercept and R squared.
  lslf_fit u_fit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sums_valid_i (sums_valid),
    .sums_i       (sums),
    .busy_o       (fit_busy),
    .done_o       (done_o),
    .result_o     (result_o)
  );

  `LSLF_ASSERT_NXT(a_busy_after_accept, accept, busy, "block not busy after an item")
  `LSLF_ASSERT_NXT(a_no_early_result, accept, !done_o, "result right after an item")
  `LSLF_ASSERT_IMP(a_r2_range, done_o, result_o.r_squared <= 17'd65536, "R squared above one")
  `LSLF_ASSERT_IMP(a_flat_x_zero, done_o && (result_o.fit_status == lslf_pkg::ST_X_FLAT), (result_o.slope == 32'sd0) && (result_o.intercept == 32'sd0) && (result_o.r_squared == 17'd0), "nonzero fit with flat x")

endmodule

FILE: verif/testbench.sv
module testbench;

  // Wide signed type for exact evaluation of the fit terms. The largest term is the
  // r-squared numerator, about 152 bits.
  typedef logic signed [255:0] wide_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  lslf_pkg::point_t      item_i = '0;
  logic                  done_o;
  lslf_pkg::fit_result_t result_o;

  least_squares_line_fit_unit u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Running totals of the data set being loaded, mirrored from the block.
  longint n_pts, sum_x, sum_y, sum_xx, sum_yy, sum_xy;
  lslf_pkg::fit_result_t expected_fits[$];
  int  mismatches = 0;
  int  fits_seen = 0;
  int  points_sent = 0;
  bit  steady_send = 0;

  function automatic logic [31:0] rounded_sat(input wide_t num, input wide_t den,
                                              inout bit sat);
    wide_t mag, q, lim;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    lim = (num < 0) ? wide_t'(64'h8000_0000) : wide_t'(64'h7FFF_FFFF);
    if (q > lim) begin
      q = lim;
      sat = 1;
    end
    return (num < 0) ? 32'(-q) : 32'(q);
  endfunction

  function automatic lslf_pkg::fit_result_t line_fit();
    lslf_pkg::fit_result_t r;
    wide_t n, sx, sy, dxx, dyy, dxy, q;
    bit sat;
    sat = 0;
    n = n_pts;
    sx = sum_x;
    sy = sum_y;
    dxx = n * wide_t'(sum_xx) - sx * sx;
    dyy = n * wide_t'(sum_yy) - sy * sy;
    dxy = n * wide_t'(sum_xy) - sx * sy;
    r = '0;
    r.points_used = 11'(n_pts);
    if (dxx <= 0) begin
      r.fit_status = lslf_pkg::ST_X_FLAT;
    end else begin
      r.slope = rounded_sat(dxy * 65536, dxx, sat);
      r.intercept = rounded_sat(sy * wide_t'(sum_xx) - sx * wide_t'(sum_xy), dxx, sat);
      if (dyy <= 0) begin
        r.fit_status = lslf_pkg::ST_Y_FLAT;
      end else begin
        q = (2 * (dxy * dxy * 65536) + dxx * dyy) / (2 * (dxx * dyy));
        r.r_squared = (q > 65536) ? 17'd65536 : 17'(q);
        r.fit_status = sat ? lslf_pkg::ST_SAT : lslf_pkg::ST_OK;
      end
    end
    return r;
  endfunction

  // Mirrors one accepted point; a point past the store limit is dropped.
  task automatic absorb_point(input lslf_pkg::point_t p);
    longint x, y;
    x = p.x_value;
    y = p.y_value;
    if (n_pts < lslf_pkg::MAX_POINTS) begin
      sum_x += x;
      sum_y += y;
      sum_xx += x * x;
      sum_yy += y * y;
      sum_xy += x * y;
      n_pts++;
    end
    if (p.last_point) begin
      expected_fits = {expected_fits, line_fit()};
      n_pts = 0;
      sum_x = 0; sum_y = 0; sum_xx = 0; sum_yy = 0; sum_xy = 0;
    end
  endtask

  // Offers one point and holds it until the block takes it, then maybe pauses.
  // A pause outlasts the busy period after a point not marked last, so the block then
  // sits free but unused until the next point is offered.
  task automatic send_point(input logic signed [23:0] x, input logic signed [23:0] y,
                            input bit last);
    lslf_pkg::point_t p;
    p.x_value = x;
    p.y_value = y;
    p.last_point = last;
    start <= 1'b1;
    item_i <= p;
    do @(posedge clk_i); while (busy);
    absorb_point(p);
    points_sent++;
    if (!steady_send && $urandom_range(99) < 25) begin
      start <= 1'b0;
      repeat ($urandom_range(7, 12)) @(posedge clk_i);
    end
  endtask

  // Checks every fit that the block shows against the oldest prediction.
  always @(posedge clk_i) begin
    lslf_pkg::fit_result_t e;
    if (rst_ni && done_o) begin
      fits_seen++;
      if (expected_fits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected fit result %p", result_o);
      end else begin
        e = expected_fits.pop_front();
        if (result_o !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("fit mismatch: expected %p, got %p", e, result_o);
        end
      end
    end
  end

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(0, 4095)) - 2048);
      2: return $urandom_range(1) ? 24'sh7FFFFF : -24'sh800000;
      default: return 24'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  // Extremes, a single point, flat x, flat y, an exact line and a saturating slope.
  task automatic test_directed();
    send_point(24'sh7FFFFF, -24'sh800000, 1);
    send_point(-24'sh800000, 24'sh7FFFFF, 0);
    send_point(24'sh7FFFFF, -24'sh800000, 0);
    send_point(24'sh000000, 24'sh000000, 1);
    send_point(24'sh010000, 24'sh123456, 0);
    send_point(24'sh010000, -24'sh054321, 0);
    send_point(24'sh010000, 24'sh000001, 1);
    send_point(-24'sh030000, 24'sh020000, 0);
    send_point(24'sh040000, 24'sh020000, 0);
    send_point(24'sh7FFFFF, 24'sh020000, 1);
    for (int i = 0; i < 4; i++)
      send_point(24'(i * 32'sh10000 - 32'sh20000), 24'(i * 32'sh30000 + 32'sh8000), i == 3);
    send_point(24'sh000000, -24'sh800000, 0);
    send_point(24'sh000001, 24'sh7FFFFF, 1);
    send_point(-24'sh800000, -24'sh800000, 0);
    send_point(24'sh7FFFFF, 24'sh7FFFFF, 0);
    send_point(24'sh000000, 24'sh7FFFFF, 1);
  endtask

  // More points than the store holds: the surplus must be ignored by the fit.
  task automatic test_store_full();
    for (int i = 0; i < lslf_pkg::MAX_POINTS + 6; i++)
      send_point(rand_coord(), rand_coord(), i == lslf_pkg::MAX_POINTS + 5);
  endtask

  // Random data sets, mostly small, with flat, collinear and noisy shapes mixed in.
  task automatic test_random_sets(input int budget);
    int sent, size, shape;
    logic signed [23:0] x0, y0, dx, dy, x, y;
    sent = 0;
    while (sent < budget) begin
      steady_send = (sent > budget / 3) && (sent < budget / 2);
      size = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      shape = $urandom_range(5);
      x0 = rand_coord();
      y0 = rand_coord();
      dx = 24'($signed($urandom_range(0, 511)) - 256) <<< $urandom_range(0, 12);
      dy = 24'($signed($urandom_range(0, 511)) - 256) <<< $urandom_range(0, 12);
      for (int i = 0; i < size; i++) begin
        x = rand_coord();
        y = rand_coord();
        if (shape == 1) x = x0;
        if (shape == 2) y = y0;
        if (shape == 3) begin
          x = 24'(x0 + i * dx);
          y = 24'(y0 + i * dy);
        end
        send_point(x, y, i == size - 1);
      end
      sent += size;
    end
    steady_send = 0;
  endtask

  initial begin
    n_pts = 0;
    sum_x = 0; sum_y = 0; sum_xx = 0; sum_yy = 0; sum_xy = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_store_full();
    test_random_sets(300);
    start <= 1'b0;
    while (expected_fits.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Sent %0d points, checked %0d fits including a store overflow set.",
             points_sent, fits_seen);
    $display("Mismatches: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("Timed out with %0d fits outstanding.", expected_fits.size());
    $display("testbench: errors");
    $finish;
  end

endmodule
